FILE: sv/assert_macros.svh
// ----------------------------------------------------------------------------
// assertion helpers shared by the rtl
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// next-cycle implication, disabled during reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

FILE: sv/fatlb_pkg.sv
// ----------------------------------------------------------------------------
// fatlb_pkg
// types and constants for the fully associative tlb
// ----------------------------------------------------------------------------
package fatlb_pkg;

    // command codes
    typedef enum logic [1:0] {
        CMD_LOOKUP = 2'd0,
        CMD_INSERT = 2'd1,
        CMD_INVAL  = 2'd2,
        CMD_FLUSH  = 2'd3
    } t_cmd;

    // configuration register indexes
    localparam int CFG_IDX_W = 1;
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PAGE_SHIFT  = 1'd0,
        CFG_BYPASS_MASK = 1'd1
    } t_cfg_idx;

    localparam int CFG_DATA_W   = 32;
    localparam int FIELD_ADDR_W = 32;
    localparam int SHIFT_W      = 5;
    localparam int INDEX_W      = 6;

    localparam logic [SHIFT_W-1:0]      PAGE_SHIFT_RESET  = 5'd12;
    localparam logic [CFG_DATA_W-1:0]   BYPASS_MASK_RESET = 32'hFFFF_FFFF;

    // input beat
    typedef struct packed {
        t_cmd                      command;
        logic [INDEX_W-1:0]        entry_index;
        logic [FIELD_ADDR_W-1:0]   virtual_address;
        logic [FIELD_ADDR_W-1:0]   target_address;
        logic [FIELD_ADDR_W-1:0]   invalidate_page;
    } t_in_beat;

    // output beat
    typedef struct packed {
        logic                      hit;
        logic [FIELD_ADDR_W-1:0]   physical_address;
    } t_out_beat;

endpackage

FILE: sv/fatlb_ram.sv
// ----------------------------------------------------------------------------
// fatlb_ram
// single write port, single read port ram with registered read data
// ----------------------------------------------------------------------------
module fatlb_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                                      i_clk,
    input  logic                                      i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                          i_wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                          o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: sv/fully_associative_tlb.sv
// ----------------------------------------------------------------------------
// fully_associative_tlb: insert, flush and bypassed lookup go straight to the done state and
// register their result; other lookups and invalidates scan the entry ram one entry a cycle,
// ending at the first valid match or after the last entry; one command in flight at a time,
// the next accepted once the result is loaded into the output register, which holds under stall
// synchronous active-low reset clears all valid bits, page_shift=12, bypass_mask=all ones
// ----------------------------------------------------------------------------
module fully_associative_tlb #(
    parameter int ENTRIES    = 64,
    parameter int ADDR_WIDTH = 32
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // command channel
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  fatlb_pkg::t_in_beat               i_in_data,
    // result channel
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output fatlb_pkg::t_out_beat              o_out_data,
    // configuration writes
    input  logic                              i_cfg_we,
    input  fatlb_pkg::t_cfg_idx               i_cfg_index,
    input  logic [fatlb_pkg::CFG_DATA_W-1:0]  i_cfg_data
);

    import fatlb_pkg::*;

    localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int AW = ADDR_WIDTH;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_SCAN = 3'b010,
        ST_DONE = 3'b100
    } t_state;

    t_state                   r_state;
    t_state                   n_state;
    logic [ENTRIES-1:0]       r_valid;
    logic [SHIFT_W-1:0]       r_page_shift;
    logic [CFG_DATA_W-1:0]    r_bypass_mask;
    logic                     r_out_valid;
    t_out_beat                r_out;
    t_out_beat                r_res;
    t_cmd                     r_cmd;
    logic [AW-1:0]            r_key;
    logic [FIELD_ADDR_W-1:0]  r_va;
    logic [IW-1:0]            r_cmp_idx;

    logic                     in_accept;
    logic                     out_free;
    logic                     out_load;
    logic                     is_bypass;
    logic                     idx_ok;
    logic                     ram_we;
    logic [IW-1:0]            ram_waddr;
    logic [2*AW-1:0]          ram_wdata;
    logic [IW-1:0]            ram_raddr;
    logic [2*AW-1:0]          ram_rdata;
    logic [AW-1:0]            ent_vpage;
    logic [AW-1:0]            ent_ppage;
    logic                     scan_hit;
    logic                     scan_last;
    logic                     scan_end;
    logic                     inv_hit;
    logic [AW-1:0]            off_mask;
    logic [AW-1:0]            xlat_addr;

    // handshake
    assign in_accept  = i_in_valid && (r_state == ST_IDLE);
    assign o_in_stall = (r_state != ST_IDLE);
    assign out_free   = !r_out_valid || !i_out_stall;
    assign out_load   = (r_state == ST_DONE) && out_free;

    // command decode
    assign is_bypass = ((i_in_data.virtual_address & r_bypass_mask) == '0);
    assign idx_ok    = (32'(i_in_data.entry_index) < ENTRIES);

    // insert writes both pages of one entry
    assign ram_we    = in_accept && (i_in_data.command == CMD_INSERT) && idx_ok;
    assign ram_waddr = IW'(i_in_data.entry_index);
    assign ram_wdata = {AW'(i_in_data.target_address) >> r_page_shift,
                        AW'(i_in_data.virtual_address) >> r_page_shift};

    // scan compare on the entry read last cycle
    assign ent_vpage = ram_rdata[AW-1:0];
    assign ent_ppage = ram_rdata[2*AW-1:AW];
    assign scan_hit  = r_valid[r_cmp_idx] && (ent_vpage == r_key);
    assign scan_last = (r_cmp_idx == IW'(ENTRIES - 1));
    assign scan_end  = (r_state == ST_SCAN) && (scan_hit || scan_last);
    assign inv_hit   = (r_state == ST_SCAN) && (r_cmd == CMD_INVAL) && scan_hit;
    assign ram_raddr = (r_state == ST_SCAN && !scan_last) ? r_cmp_idx + IW'(1) : '0;

    // translated address: physical page joined with the page offset
    assign off_mask  = (AW'(1) << r_page_shift) - AW'(1);
    assign xlat_addr = (ent_ppage << r_page_shift) | (AW'(r_va) & off_mask);

    fatlb_ram #(
        .WIDTH (2 * AW),
        .DEPTH (ENTRIES)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (in_accept) begin
                    if ((i_in_data.command == CMD_LOOKUP && !is_bypass) ||
                        i_in_data.command == CMD_INVAL) begin
                        n_state = ST_SCAN;
                    end else begin
                        n_state = ST_DONE;
                    end
                end
            end
            ST_SCAN: begin
                if (scan_hit || scan_last) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_IDLE;
            r_valid       <= '0;
            r_out_valid   <= 1'b0;
            r_page_shift  <= PAGE_SHIFT_RESET;
            r_bypass_mask <= BYPASS_MASK_RESET;
        end else begin
            r_state <= n_state;

            // configuration writes
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_PAGE_SHIFT:  r_page_shift  <= i_cfg_data[SHIFT_W-1:0];
                    CFG_BYPASS_MASK: r_bypass_mask <= i_cfg_data;
                    default: ;
                endcase
            end

            // valid bits
            if (in_accept && i_in_data.command == CMD_FLUSH) begin
                r_valid <= '0;
            end else if (ram_we) begin
                r_valid[ram_waddr] <= 1'b1;
            end else if (inv_hit) begin
                r_valid[r_cmp_idx] <= 1'b0;
            end

            // output register occupancy
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // command, scan and result payload
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_cmd     <= i_in_data.command;
            r_va      <= i_in_data.virtual_address;
            r_cmp_idx <= '0;
            if (i_in_data.command == CMD_INVAL) begin
                r_key <= AW'(i_in_data.invalidate_page);
            end else begin
                r_key <= AW'(i_in_data.virtual_address) >> r_page_shift;
            end
            r_res.hit              <= (i_in_data.command == CMD_LOOKUP) && is_bypass;
            r_res.physical_address <= (i_in_data.command == CMD_LOOKUP) ?
                                      i_in_data.virtual_address : '0;
        end else if (r_state == ST_SCAN) begin
            r_cmp_idx <= r_cmp_idx + IW'(1);
            if (scan_hit || scan_last) begin
                r_res.hit <= scan_hit;
                case (r_cmd)
                    CMD_LOOKUP: begin
                        r_res.physical_address <= scan_hit ? FIELD_ADDR_W'(xlat_addr) : r_va;
                    end
                    default: r_res.physical_address <= '0;
                endcase
            end
        end
        if (out_load) begin
            r_out <= r_res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // checks
`include "assert_macros.svh"

    `ASSERT_NEXT(a_scan_ends, i_clk, i_rst_n, scan_end, r_state == ST_DONE)
    `ASSERT_NEXT(a_inval_one, i_clk, i_rst_n, inv_hit, $onehot($past(r_valid) & ~r_valid))
    `ASSERT_NEXT(a_result_out, i_clk, i_rst_n, out_load, (r_state == ST_IDLE) && r_out_valid)

endmodule
